### hdl/msdrq_pkg.sv
// Shared types and codes for the multi-slot delta ring queue.
`default_nettype none

package msdrq_pkg;

    // Operation codes carried in the func field.
    localparam logic [1:0] FUNC_ENQ  = 2'd0;
    localparam logic [1:0] FUNC_DEQ  = 2'd1;
    localparam logic [1:0] FUNC_PARK = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // Operations of the shared pointer unit.
    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  tick;
        logic [3:0]  burst_len;
        logic [63:0] row_s;
        logic [63:0] row_p;
        logic [63:0] row_o;
        logic [63:0] row_cycle;
        logic [7:0]  capacity;
        logic [5:0]  slot_index;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] out_s;
        logic [63:0] out_p;
        logic [63:0] out_o;
        logic [63:0] out_cycle;
        logic        row_valid;
        logic        last;
        logic        queue_empty;
    } out_t;

    // One stored row of the ring.
    typedef struct packed {
        logic [63:0] s;
        logic [63:0] p;
        logic [63:0] o;
        logic [63:0] cycle;
    } row_t;

endpackage

`default_nettype wire

### hdl/multi_slot_delta_ring_queue.sv
// Top level: sequencer, per-tick pointers and burst bookkeeping of the ring queue.
`default_nettype none

// Eight (TICK_SLOTS) ring queues of rows share one row memory, each tick owning a
// partition of RING_DEPTH entries (a power of two); pointers run modulo twice the
// depth. An item is handled by a small sequencer that drives one shared pointer
// add/subtract unit and the row memory's write and read ports, and in_ready is
// high only while the sequencer is idle. Steps per item, after the accept:
// an enqueue row passes the occupancy check and the row write; the first row of
// a burst adds a pass through the pointer unit for the space check, and one more
// for the write pointer when it reserves space; park and bad arguments go from the
// occupancy check to the reply; a dequeue counts its readable rows, then replies
// empty if there are none, or reads each row from memory and outputs it in turn.
// Results sit in an output register, so the next item is taken while the last
// result still waits; a full output register stalls the sequencer before it loads
// a new result. Row valid marks are not stored per entry: inside a queue every
// reserved row is written except the unwritten tail of a burst still in flight,
// so a dequeue takes the valid count from the burst base pointer. This needs no
// clearing pass after reset. A parked mark changes no later result, so park only
// checks its arguments and answers.
module multi_slot_delta_ring_queue #(
    parameter int TICK_SLOTS     = 8,
    parameter int RING_DEPTH     = 64,
    parameter int ROWS_PER_BURST = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire msdrq_pkg::in_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output msdrq_pkg::out_t     out_data
);

    localparam int IDX_W     = $clog2(RING_DEPTH);
    localparam int PTR_W     = IDX_W + 1;
    localparam int TICK_W    = (TICK_SLOTS > 1) ? $clog2(TICK_SLOTS) : 1;
    localparam int ADDR_W    = TICK_W + IDX_W;
    localparam int MEM_DEPTH = TICK_SLOTS * RING_DEPTH;
    localparam int CNT_W     = $clog2(ROWS_PER_BURST + 1);
    localparam int MIN_W     = (PTR_W > 8) ? PTR_W : 8;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_OCC   = 9'b000000010,
        S_RESV  = 9'b000000100,
        S_WPADV = 9'b000001000,
        S_ENQ   = 9'b000010000,
        S_DCNT  = 9'b000100000,
        S_DREAD = 9'b001000000,
        S_DOUT  = 9'b010000000,
        S_REPLY = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    msdrq_pkg::in_t  item_reg, item_next;
    msdrq_pkg::out_t out_data_reg, out_data_next;
    logic            out_valid_reg, out_valid_next;

    logic [PTR_W-1:0] wp_reg [TICK_SLOTS];
    logic [PTR_W-1:0] rp_reg [TICK_SLOTS];
    logic             wp_we, rp_we;
    logic [PTR_W-1:0] wp_wdata, rp_wdata;

    logic [3:0]       burst_left_reg, burst_left_next;
    logic [PTR_W-1:0] burst_base_reg, burst_base_next;
    logic [2:0]       burst_tick_reg, burst_tick_next;
    logic             burst_ok_reg, burst_ok_next;

    logic [PTR_W-1:0] occ_reg, occ_next;
    logic [1:0]       st_reg, st_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic             empty_reg, empty_next;

    // Tick selection and argument checks.
    logic [2:0]        tsel;
    logic              tick_ok;
    logic [TICK_W-1:0] tidx;
    logic [PTR_W-1:0]  wp_sel, rp_sel;
    logic              empty_simple;
    logic              first_bad, deq_bad, park_bad, pending;
    logic              out_free;

    // Shared pointer unit.
    msdrq_pkg::alu_op_t alu_op;
    logic [PTR_W-1:0]   alu_a, alu_b, alu_res;
    logic               alu_over;

    // Dequeue count.
    logic [PTR_W-1:0] avail;
    logic [MIN_W-1:0] lim_cap, lim_all;
    logic [CNT_W-1:0] n_rows;

    // Row memory ports.
    logic            mem_we, mem_re;
    msdrq_pkg::row_t mem_wdata, mem_rdata;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;

    msdrq_ptr_alu #(
        .PTR_W      (PTR_W),
        .RING_DEPTH (RING_DEPTH)
    ) u_alu (
        .op   (alu_op),
        .a    (alu_a),
        .b    (alu_b),
        .res  (alu_res),
        .over (alu_over)
    );

    msdrq_row_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (MEM_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A later row of a burst works on the burst's tick; everything else on its own.
    assign tsel = (item_reg.func == msdrq_pkg::FUNC_ENQ && burst_left_reg != '0)
                  ? burst_tick_reg : item_reg.tick;
    assign tick_ok      = 32'(tsel) < TICK_SLOTS;
    assign tidx         = tick_ok ? TICK_W'(tsel) : '0;
    assign wp_sel       = wp_reg[tidx];
    assign rp_sel       = rp_reg[tidx];
    assign empty_simple = !tick_ok || (occ_reg == '0);

    assign first_bad = (item_reg.burst_len == '0)
                       || (32'(item_reg.burst_len) > ROWS_PER_BURST)
                       || (32'(item_reg.tick) >= TICK_SLOTS);
    assign deq_bad   = (item_reg.capacity == '0) || !tick_ok;
    assign park_bad  = !tick_ok || (32'(item_reg.slot_index) >= RING_DEPTH);

    // Rows from the burst base up to the write pointer are reserved but unwritten.
    assign pending = (burst_left_reg != '0) && burst_ok_reg
                     && (burst_tick_reg == item_reg.tick);

    assign out_free = !out_valid_reg || out_ready;

    // Route the shared unit by sequencer step.
    always_comb
    begin
        alu_op = msdrq_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_OCC:
            begin
                alu_op = msdrq_pkg::ALU_SUB;
                alu_a  = wp_sel;
                alu_b  = rp_sel;
            end
            S_RESV:
            begin
                alu_a = occ_reg;
                alu_b = PTR_W'(item_reg.burst_len);
            end
            S_WPADV:
            begin
                alu_a = wp_sel;
                alu_b = PTR_W'(item_reg.burst_len);
            end
            S_ENQ:
            begin
                alu_a = burst_base_reg;
                alu_b = PTR_W'(1'b1);
            end
            S_DCNT:
            begin
                alu_op = msdrq_pkg::ALU_SUB;
                alu_a  = burst_base_reg;
                alu_b  = rp_sel;
            end
            S_DOUT:
            begin
                alu_a = rptr_reg;
                alu_b = PTR_W'(1'b1);
            end
            default:
            begin
                alu_op = msdrq_pkg::ALU_ADD;
            end
        endcase
    end

    // Clip the dequeue to the valid rows, the requester's capacity and the burst size.
    assign avail   = pending ? alu_res : occ_reg;
    assign lim_cap = (MIN_W'(avail) < MIN_W'(item_reg.capacity))
                     ? MIN_W'(avail) : MIN_W'(item_reg.capacity);
    assign lim_all = (lim_cap > MIN_W'(ROWS_PER_BURST)) ? MIN_W'(ROWS_PER_BURST) : lim_cap;
    assign n_rows  = CNT_W'(lim_all);

    assign mem_waddr = {tidx, burst_base_reg[IDX_W-1:0]};
    assign mem_raddr = {tidx, rptr_reg[IDX_W-1:0]};
    assign mem_wdata = '{s: item_reg.row_s, p: item_reg.row_p,
                         o: item_reg.row_o, cycle: item_reg.row_cycle};

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        burst_left_next = burst_left_reg;
        burst_base_next = burst_base_reg;
        burst_tick_next = burst_tick_reg;
        burst_ok_next   = burst_ok_reg;
        occ_next        = occ_reg;
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        rptr_next       = rptr_reg;
        empty_next      = empty_reg;
        wp_we           = 1'b0;
        wp_wdata        = alu_res;
        rp_we           = 1'b0;
        rp_wdata        = alu_res;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = S_OCC;
                end
            end
            S_OCC:
            begin
                occ_next = alu_res;
                case (item_reg.func)
                    msdrq_pkg::FUNC_ENQ:
                    begin
                        if (burst_left_reg != '0)
                        begin
                            state_next = S_ENQ;
                        end
                        else if (first_bad)
                        begin
                            st_next    = msdrq_pkg::ST_BAD;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_RESV;
                        end
                    end
                    msdrq_pkg::FUNC_DEQ:
                    begin
                        if (deq_bad)
                        begin
                            st_next    = msdrq_pkg::ST_BAD;
                            state_next = S_REPLY;
                        end
                        else
                        begin
                            state_next = S_DCNT;
                        end
                    end
                    msdrq_pkg::FUNC_PARK:
                    begin
                        st_next    = park_bad ? msdrq_pkg::ST_BAD : msdrq_pkg::ST_OK;
                        state_next = S_REPLY;
                    end
                    default:
                    begin
                        st_next    = msdrq_pkg::ST_BAD;
                        state_next = S_REPLY;
                    end
                endcase
            end
            S_RESV:
            begin
                // Reserve the whole burst now, or mark it full for all its rows.
                burst_tick_next = item_reg.tick;
                burst_left_next = item_reg.burst_len;
                burst_ok_next   = !alu_over;
                burst_base_next = wp_sel;
                state_next      = alu_over ? S_ENQ : S_WPADV;
            end
            S_WPADV:
            begin
                wp_we      = 1'b1;
                state_next = S_ENQ;
            end
            S_ENQ:
            begin
                if (out_free)
                begin
                    burst_left_next = burst_left_reg - 4'd1;
                    if (burst_ok_reg)
                    begin
                        mem_we          = 1'b1;
                        burst_base_next = alu_res;
                    end
                    out_valid_next            = 1'b1;
                    out_data_next             = '0;
                    out_data_next.status      = burst_ok_reg ? msdrq_pkg::ST_OK
                                                             : msdrq_pkg::ST_FULL;
                    out_data_next.last        = 1'b1;
                    out_data_next.queue_empty = burst_ok_reg ? 1'b0 : empty_simple;
                    state_next                = S_IDLE;
                end
            end
            S_DCNT:
            begin
                if (n_rows == '0)
                begin
                    st_next    = msdrq_pkg::ST_EMPTY;
                    state_next = S_REPLY;
                end
                else
                begin
                    cnt_next   = n_rows;
                    empty_next = (lim_all == MIN_W'(occ_reg));
                    rptr_next  = rp_sel;
                    state_next = S_DREAD;
                end
            end
            S_DREAD:
            begin
                mem_re     = 1'b1;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = msdrq_pkg::ST_OK;
                    out_data_next.out_s       = mem_rdata.s;
                    out_data_next.out_p       = mem_rdata.p;
                    out_data_next.out_o       = mem_rdata.o;
                    out_data_next.out_cycle   = mem_rdata.cycle;
                    out_data_next.row_valid   = 1'b1;
                    out_data_next.last        = (cnt_reg == CNT_W'(1));
                    out_data_next.queue_empty = empty_reg;
                    rptr_next                 = alu_res;
                    cnt_next                  = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        // Advance the read pointer by the rows actually read.
                        rp_we      = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DREAD;
                    end
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next             = '0;
                    out_data_next.status      = st_reg;
                    out_data_next.last        = 1'b1;
                    out_data_next.queue_empty = empty_simple;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            burst_left_reg <= '0;
            burst_base_reg <= '0;
            burst_tick_reg <= '0;
            burst_ok_reg   <= 1'b0;
            for (int i = 0; i < TICK_SLOTS; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            burst_left_reg <= burst_left_next;
            burst_base_reg <= burst_base_next;
            burst_tick_reg <= burst_tick_next;
            burst_ok_reg   <= burst_ok_next;
            if (wp_we)
            begin
                wp_reg[tidx] <= wp_wdata;
            end
            if (rp_we)
            begin
                rp_reg[tidx] <= rp_wdata;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        out_data_reg <= out_data_next;
        occ_reg      <= occ_next;
        st_reg       <= st_next;
        cnt_reg      <= cnt_next;
        rptr_reg     <= rptr_next;
        empty_reg    <= empty_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    a_row_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.row_valid) |-> (out_data_reg.status == msdrq_pkg::ST_OK))
        else $error("row result without ok status");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(burst_left_reg) <= ROWS_PER_BURST)
        else $error("burst row count beyond burst size");

    a_write_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (burst_ok_reg && burst_left_reg != '0))
        else $error("row written outside a reserved burst");

    a_dequeue_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOUT && out_free && cnt_reg == CNT_W'(1))
        |=> (out_valid_reg && out_data_reg.last && state_reg == S_IDLE))
        else $error("final dequeued row not marked last");
`endif

endmodule

`default_nettype wire

### hdl/msdrq_ptr_alu.sv
// Shared pointer add/subtract unit with ring-depth overflow compare.
`default_nettype none

module msdrq_ptr_alu #(
    parameter int PTR_W      = 7,
    parameter int RING_DEPTH = 64
) (
    input  wire msdrq_pkg::alu_op_t op,
    input  wire logic [PTR_W-1:0]   a,
    input  wire logic [PTR_W-1:0]   b,
    output logic      [PTR_W-1:0]   res,
    output logic                    over
);

    logic [PTR_W:0] sum;

    always_comb
    begin
        case (op)
            msdrq_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            msdrq_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default:            sum = '0;
        endcase
    end

    // Wrap modulo twice the ring depth; flag a sum that overfills a partition.
    assign res  = sum[PTR_W-1:0];
    assign over = (op == msdrq_pkg::ALU_ADD) && (32'(sum) > RING_DEPTH);

endmodule

`default_nettype wire

### hdl/msdrq_row_mem.sv
// Row storage for all tick partitions: one write port, one registered read port.
`default_nettype none

module msdrq_row_mem #(
    parameter int ADDR_W = 9,
    parameter int DEPTH  = 512
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire msdrq_pkg::row_t   wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output msdrq_pkg::row_t        rdata
);

    msdrq_pkg::row_t mem [DEPTH];
    msdrq_pkg::row_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sim/multi_slot_delta_ring_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multi-slot delta ring queue: directed, fill and random traffic.
module multi_slot_delta_ring_queue_test;

    localparam int TICKS         = 8;
    localparam int DEPTH         = 64;
    localparam int MAX_BURST     = 8;
    // Wait after the drain for stray results, sized from an eight-row dequeue inside the block.
    localparam int SETTLE_CYCLES = 40;
    // Watchdog limit, set far above the slowest legal run even with the receiver stalling hard.
    localparam int CYCLE_LIMIT   = 400000;

    // The block answers an unknown operation code with a bad-argument status.
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    msdrq_pkg::in_t  in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    msdrq_pkg::out_t out_data;

    multi_slot_delta_ring_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Idle rates in percent; the main sequence changes them between phases.
    int send_idle_pct = 31;
    int recv_idle_pct = 78;
    int failures      = 0;
    int cycle_count   = 0;

    // ------------------------------------------------------------------
    // Ring queue predictor: its own pointers, row store and burst state.
    // ------------------------------------------------------------------
    logic [6:0]      wr_ptr [TICKS] = '{default: '0};
    logic [6:0]      rd_ptr [TICKS] = '{default: '0};
    msdrq_pkg::row_t ring_rows   [TICKS*DEPTH];
    bit              row_written [TICKS*DEPTH];
    bit              row_parked  [TICKS*DEPTH];
    logic [3:0]      rows_left   = '0;
    logic [6:0]      burst_ptr   = '0;
    logic [2:0]      burst_tick  = '0;
    bit              burst_fits  = 1'b0;

    // Results the block still owes, oldest first.
    msdrq_pkg::out_t pending_results [$];
    msdrq_pkg::out_t oldest;

    // Pointers run modulo twice the depth, so a 7-bit difference is the fill level.
    function automatic logic [6:0] rows_held(logic [2:0] t);
        return wr_ptr[t] - rd_ptr[t];
    endfunction

    function automatic int ring_index(logic [2:0] t, logic [6:0] ptr);
        return int'(t) * DEPTH + int'(ptr[5:0]);
    endfunction

    // Queue one expected result; the empty flag reflects the tick after the operation.
    task automatic post_result(logic [1:0] status, msdrq_pkg::row_t row, logic carries_row,
                               logic is_last, logic [2:0] t);
        msdrq_pkg::out_t r;
        r.status      = status;
        r.out_s       = row.s;
        r.out_p       = row.p;
        r.out_o       = row.o;
        r.out_cycle   = row.cycle;
        r.row_valid   = carries_row;
        r.last        = is_last;
        r.queue_empty = (rows_held(t) == 7'd0);
        pending_results.push_back(r);
    endtask

    task automatic apply_enqueue(msdrq_pkg::in_t item);
        msdrq_pkg::row_t row;
        int              idx;
        if (rows_left == 4'd0)
        begin
            // First row of a burst: check the length, then reserve the whole burst or none.
            if (item.burst_len == 4'd0 || int'(item.burst_len) > MAX_BURST)
            begin
                post_result(msdrq_pkg::ST_BAD, '0, 1'b0, 1'b1, item.tick);
                return;
            end
            burst_tick = item.tick;
            rows_left  = item.burst_len;
            burst_fits = (int'(rows_held(item.tick)) + int'(item.burst_len) <= DEPTH);
            if (burst_fits)
            begin
                burst_ptr         = wr_ptr[item.tick];
                wr_ptr[item.tick] = 7'(wr_ptr[item.tick] + item.burst_len);
            end
        end
        rows_left = rows_left - 4'd1;
        if (!burst_fits)
        begin
            post_result(msdrq_pkg::ST_FULL, '0, 1'b0, 1'b1, burst_tick);
            return;
        end
        idx              = ring_index(burst_tick, burst_ptr);
        row.s            = item.row_s;
        row.p            = item.row_p;
        row.o            = item.row_o;
        row.cycle        = item.row_cycle;
        ring_rows[idx]   = row;
        row_written[idx] = 1'b1;
        row_parked[idx]  = 1'b0;
        burst_ptr        = burst_ptr + 7'd1;
        post_result(msdrq_pkg::ST_OK, '0, 1'b0, 1'b1, burst_tick);
    endtask

    task automatic apply_dequeue(msdrq_pkg::in_t item);
        msdrq_pkg::row_t taken [MAX_BURST];
        int              want;
        int              got;
        int              idx;
        if (item.capacity == 8'd0)
        begin
            post_result(msdrq_pkg::ST_BAD, '0, 1'b0, 1'b1, item.tick);
            return;
        end
        want = int'(rows_held(item.tick));
        if (want > int'(item.capacity)) want = int'(item.capacity);
        if (want > MAX_BURST) want = MAX_BURST;
        got = 0;
        // Stop at the first reserved row that has not been written yet.
        while (got < want)
        begin
            idx = ring_index(item.tick, 7'(rd_ptr[item.tick] + got));
            if (!row_written[idx]) break;
            taken[got]       = ring_rows[idx];
            row_written[idx] = 1'b0;
            row_parked[idx]  = 1'b0;
            got++;
        end
        if (got == 0)
        begin
            post_result(msdrq_pkg::ST_EMPTY, '0, 1'b0, 1'b1, item.tick);
            return;
        end
        // Advance the read pointer only by the rows actually read.
        rd_ptr[item.tick] = 7'(rd_ptr[item.tick] + got);
        for (int k = 0; k < got; k++)
            post_result(msdrq_pkg::ST_OK, taken[k], 1'b1, k == got - 1, item.tick);
    endtask

    task automatic predict_results(msdrq_pkg::in_t item);
        case (item.func)
            msdrq_pkg::FUNC_ENQ:  apply_enqueue(item);
            msdrq_pkg::FUNC_DEQ:  apply_dequeue(item);
            msdrq_pkg::FUNC_PARK:
            begin
                row_parked[ring_index(item.tick, 7'(item.slot_index))] = 1'b1;
                post_result(msdrq_pkg::ST_OK, '0, 1'b0, 1'b1, item.tick);
            end
            default:   post_result(msdrq_pkg::ST_BAD, '0, 1'b0, 1'b1, item.tick);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Sender side. Every task returns just after a falling edge with no
    // pending change, so the next call may raise valid in the same step.
    // ------------------------------------------------------------------
    function automatic msdrq_pkg::in_t fresh_item(logic [1:0] func, logic [2:0] tick);
        msdrq_pkg::in_t item;
        item.func       = func;
        item.tick       = tick;
        item.burst_len  = 4'($urandom_range(0, MAX_BURST));
        item.row_s      = {$urandom, $urandom};
        item.row_p      = {$urandom, $urandom};
        item.row_o      = {$urandom, $urandom};
        item.row_cycle  = {$urandom, $urandom};
        item.capacity   = 8'($urandom_range(0, 255));
        item.slot_index = 6'($urandom_range(0, DEPTH - 1));
        return item;
    endfunction

    // Drive one transfer and predict its results once the block takes it.
    task automatic send_item(msdrq_pkg::in_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_results(item);
        @(negedge clk);
    endtask

    // Drop valid and hold off until the block has delivered everything owed.
    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
    endtask

    // Send one burst of rows; later rows carry junk tick and length, which the block ignores.
    // With cut_at in range, slip a dequeue or park on the same tick in before that row.
    task automatic send_burst(logic [2:0] t, int len, int cut_at);
        msdrq_pkg::in_t item;
        for (int r = 0; r < len; r++)
        begin
            if (r == cut_at)
            begin
                item = fresh_item($urandom_range(1) ? msdrq_pkg::FUNC_DEQ
                                                    : msdrq_pkg::FUNC_PARK, t);
                send_item(item);
            end
            item = fresh_item(msdrq_pkg::FUNC_ENQ,
                              r == 0 ? t : 3'($urandom_range(0, TICKS - 1)));
            if (r == 0) item.burst_len = 4'(len);
            send_item(item);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        msdrq_pkg::in_t item;
        // Empty queue, zero capacity, park at both slot extremes, unknown operation.
        item = fresh_item(msdrq_pkg::FUNC_DEQ, 3'd0);
        item.capacity = 8'd5;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_DEQ, 3'd1);
        item.capacity = 8'd0;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_PARK, 3'd3);
        item.slot_index = 6'd63;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_PARK, 3'd4);
        item.slot_index = 6'd0;
        send_item(item);
        item = fresh_item(FUNC_UNKNOWN, 3'd5);
        send_item(item);
        // Bad burst lengths on a first row: zero, just above the limit, all ones.
        item = fresh_item(msdrq_pkg::FUNC_ENQ, 3'd2);
        item.burst_len = 4'd0;
        send_item(item);
        item.burst_len = 4'd9;
        send_item(item);
        item.burst_len = 4'd15;
        send_item(item);

        // Three-row burst on tick 7 with all-ones and all-zero rows; dequeue mid-burst
        // must stop at the row that is reserved but not written yet.
        item = fresh_item(msdrq_pkg::FUNC_ENQ, 3'd7);
        item.burst_len = 4'd3;
        item.row_s = '1;
        item.row_p = '1;
        item.row_o = '1;
        item.row_cycle = '1;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_ENQ, 3'd2);
        item.burst_len = 4'd0;
        item.row_s = '0;
        item.row_p = '0;
        item.row_o = '0;
        item.row_cycle = '0;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_DEQ, 3'd7);
        item.capacity = 8'd255;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_PARK, 3'd7);
        item.slot_index = 6'd2;
        send_item(item);
        item = fresh_item(msdrq_pkg::FUNC_ENQ, 3'd5);
        item.burst_len = 4'd8;
        send_item(item);
        // Let every owed result drain out before the next request.
        hold_until_drained();
        item = fresh_item(msdrq_pkg::FUNC_DEQ, 3'd7);
        item.capacity = 8'd8;
        send_item(item);

        // Longest burst, then a capacity of one and a capacity above what is left.
        send_burst(3'd0, MAX_BURST, -1);
        item = fresh_item(msdrq_pkg::FUNC_DEQ, 3'd0);
        item.capacity = 8'd1;
        send_item(item);
        item.capacity = 8'd255;
        send_item(item);
    endtask

    // Nine full bursts into one tick: the last one finds no room and every row is
    // answered full. Then dequeue part of it back out.
    task automatic test_fill_to_full();
        msdrq_pkg::in_t item;
        logic [2:0]     t;
        t = 3'($urandom_range(0, TICKS - 1));
        repeat (DEPTH / MAX_BURST + 1) send_burst(t, MAX_BURST, -1);
        repeat (MAX_BURST)
        begin
            item = fresh_item(msdrq_pkg::FUNC_DEQ, t);
            item.capacity = 8'($urandom_range(1, 12));
            send_item(item);
        end
    endtask

    // Mostly well-formed bursts with random content, some interrupted, mixed with
    // dequeues, parks, malformed first rows and the odd full drain.
    task automatic test_random_mix(int n_items);
        msdrq_pkg::in_t item;
        logic [2:0]     t;
        int             sent;
        int             pick;
        int             len;
        int             cut;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            t    = 3'($urandom_range(0, TICKS - 1));
            if (pick < 50)
            begin
                len = $urandom_range(1, MAX_BURST);
                cut = ($urandom_range(3) == 0) ? $urandom_range(0, len - 1) : -1;
                send_burst(t, len, cut);
                sent += len + (cut >= 0 ? 1 : 0);
            end
            else if (pick < 80)
            begin
                item = fresh_item(msdrq_pkg::FUNC_DEQ, t);
                pick = $urandom_range(99);
                if (pick < 70) item.capacity = 8'($urandom_range(1, 10));
                else if (pick < 85) item.capacity = 8'd255;
                send_item(item);
                sent++;
            end
            else if (pick < 88)
            begin
                send_item(fresh_item(msdrq_pkg::FUNC_PARK, t));
                sent++;
            end
            else if (pick < 96)
            begin
                item = fresh_item($urandom_range(3) == 0 ? FUNC_UNKNOWN
                                                         : msdrq_pkg::FUNC_ENQ, t);
                item.burst_len = $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
                send_item(item);
                sent++;
            end
            else
            begin
                hold_until_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side and checking
    // ------------------------------------------------------------------
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            failures++;
        end
    endtask

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
                failures++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                check_field("status", 64'(oldest.status), 64'(out_data.status));
                check_field("out_s", oldest.out_s, out_data.out_s);
                check_field("out_p", oldest.out_p, out_data.out_p);
                check_field("out_o", oldest.out_o, out_data.out_o);
                check_field("out_cycle", oldest.out_cycle, out_data.out_cycle);
                check_field("row_valid", 64'(oldest.row_valid), 64'(out_data.row_valid));
                check_field("last", 64'(oldest.last), 64'(out_data.last));
                check_field("queue_empty", 64'(oldest.queue_empty),
                            64'(out_data.queue_empty));
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls hard.
        send_idle_pct = 31;
        recv_idle_pct = 78;
        test_directed();
        test_fill_to_full();

        // Swap the pressure: sender slow, receiver mostly ready.
        send_idle_pct = 78;
        recv_idle_pct = 31;
        test_random_mix(13);

        // Back-to-back traffic with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(13);

        // Drain, then give the block time to show any stray result.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### multi_slot_delta_ring_queue.f
hdl/msdrq_pkg.sv
hdl/msdrq_ptr_alu.sv
hdl/msdrq_row_mem.sv
hdl/multi_slot_delta_ring_queue.sv
sim/multi_slot_delta_ring_queue_test.sv
